// ===== rtl/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// msq_pkg: shared definitions for the marching squares cell core
// Default widths, register indexes, edge codes and the segment control word.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

   localparam int DEF_SAMPLE_WIDTH = 16;
   localparam int DEF_INDEX_WIDTH  = 10;
   localparam int DEF_FRAC_BITS    = 16;

   // Width of the case index (one bit per corner).
   localparam int CASE_W = 4;

   // Segment queue depth, a power of two.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam int CFG_INDEX_W = 3;
   localparam logic [CFG_INDEX_W-1:0] REG_LEVEL    = 3'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X = 3'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y = 3'd2;
   localparam logic [CFG_INDEX_W-1:0] REG_STEP_X   = 3'd3;
   localparam logic [CFG_INDEX_W-1:0] REG_STEP_Y   = 3'd4;

   typedef enum logic [1:0] {
      EDGE_LEFT,
      EDGE_BOTTOM,
      EDGE_TOP,
      EDGE_RIGHT
   } edge_type;

   // Control part of one queued segment.
   typedef struct packed {
      edge_type           edge0;
      edge_type           edge1;
      logic [CASE_W-1:0]  case_idx;
      logic               last;
   } seg_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/msq_fifo.sv =====
// ----------------------------------------------------------------------------
// msq_fifo: short segment queue
// Register-based first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msq_front.sv =====
// ----------------------------------------------------------------------------
// msq_front: cell classification
// Registers a cell, forms its case index and hands out one queue entry per
// segment with the edge codes and the interpolation magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_front
   import msq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int INDEX_WIDTH  = DEF_INDEX_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic signed [SAMPLE_WIDTH-1:0] level,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] corner_a,
   input  wire logic signed [SAMPLE_WIDTH-1:0] corner_b,
   input  wire logic signed [SAMPLE_WIDTH-1:0] corner_c,
   input  wire logic signed [SAMPLE_WIDTH-1:0] corner_d,
   input  wire logic        [INDEX_WIDTH-1:0]  cell_col,
   input  wire logic        [INDEX_WIDTH-1:0]  cell_row,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output seg_ctrl_type                        out_ctrl,
   output logic             [SAMPLE_WIDTH:0]   out_num0,
   output logic             [SAMPLE_WIDTH:0]   out_den0,
   output logic             [SAMPLE_WIDTH:0]   out_num1,
   output logic             [SAMPLE_WIDTH:0]   out_den1,
   output logic             [INDEX_WIDTH-1:0]  out_col,
   output logic             [INDEX_WIDTH-1:0]  out_row
);

   localparam int MAG_W = SAMPLE_WIDTH + 1;

   logic                           hold_ff;
   logic                           second_ff;
   logic signed [SAMPLE_WIDTH-1:0] a_ff, b_ff, c_ff, d_ff;
   logic        [INDEX_WIDTH-1:0]  col_ff, row_ff;

   logic [CASE_W-1:0] case_idx;
   logic              two_seg;
   logic              empty;
   edge_type          e0, e1, e2, e3;
   edge_type          cur0, cur1;
   logic              last;
   logic              advance;
   logic              accept;

   // Magnitude of x - y, exact in one extra bit.
   function automatic logic [MAG_W-1:0] abs_diff(
      input logic signed [SAMPLE_WIDTH-1:0] x,
      input logic signed [SAMPLE_WIDTH-1:0] y
   );
      logic signed [MAG_W-1:0] diff;
      diff = MAG_W'(x) - MAG_W'(y);
      return diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   endfunction

   // Magnitudes for an edge: distance from the level and the edge span, both
   // measured from the edge's first corner.
   function automatic logic [2*MAG_W-1:0] edge_mags(input edge_type e);
      logic signed [SAMPLE_WIDTH-1:0] p;
      logic signed [SAMPLE_WIDTH-1:0] q;
      unique case (e)
         EDGE_LEFT:   begin p = a_ff; q = d_ff; end
         EDGE_BOTTOM: begin p = a_ff; q = b_ff; end
         EDGE_TOP:    begin p = d_ff; q = c_ff; end
         EDGE_RIGHT:  begin p = b_ff; q = c_ff; end
      endcase
      return {abs_diff(q, p), abs_diff(level, p)};
   endfunction

   assign case_idx = {d_ff > level, c_ff > level, b_ff > level, a_ff > level};

   always_comb begin
      two_seg = 1'b0;
      empty   = 1'b0;
      e0      = EDGE_LEFT;
      e1      = EDGE_BOTTOM;
      e2      = EDGE_TOP;
      e3      = EDGE_RIGHT;
      unique case (case_idx) inside
         4'd1, 4'd14: begin e0 = EDGE_LEFT;   e1 = EDGE_BOTTOM; end
         4'd7, 4'd8:  begin e0 = EDGE_LEFT;   e1 = EDGE_TOP;    end
         4'd4, 4'd11: begin e0 = EDGE_TOP;    e1 = EDGE_RIGHT;  end
         4'd2, 4'd13: begin e0 = EDGE_BOTTOM; e1 = EDGE_RIGHT;  end
         4'd6, 4'd9:  begin e0 = EDGE_BOTTOM; e1 = EDGE_TOP;    end
         4'd3, 4'd12: begin e0 = EDGE_LEFT;   e1 = EDGE_RIGHT;  end
         4'd10: begin
            e0 = EDGE_LEFT; e1 = EDGE_BOTTOM; e2 = EDGE_TOP; e3 = EDGE_RIGHT;
            two_seg = 1'b1;
         end
         4'd5: begin
            e0 = EDGE_LEFT; e1 = EDGE_TOP; e2 = EDGE_BOTTOM; e3 = EDGE_RIGHT;
            two_seg = 1'b1;
         end
         default: empty = 1'b1;
      endcase
   end

   assign cur0    = second_ff ? e2 : e0;
   assign cur1    = second_ff ? e3 : e1;
   assign last    = !two_seg || second_ff;
   // An empty cell leaves without using the queue.
   assign advance = hold_ff && (empty || out_ready);
   assign in_ready = !hold_ff || (advance && last);
   assign accept   = in_valid && in_ready;

   assign out_valid         = hold_ff && !empty;
   assign out_ctrl.edge0    = cur0;
   assign out_ctrl.edge1    = cur1;
   assign out_ctrl.case_idx = case_idx;
   assign out_ctrl.last     = last;
   assign out_col = col_ff;
   assign out_row = row_ff;

   // The magnitudes read the held corners and the level as well as the edge.
   always_comb begin
      {out_den0, out_num0} = edge_mags(cur0);
      {out_den1, out_num1} = edge_mags(cur1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else if (accept) begin
         hold_ff   <= 1'b1;
         second_ff <= 1'b0;
      end else if (advance && last) begin
         hold_ff   <= 1'b0;
         second_ff <= 1'b0;
      end else if (advance) begin
         second_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff   <= corner_a;
         b_ff   <= corner_b;
         c_ff   <= corner_c;
         d_ff   <= corner_d;
         col_ff <= cell_col;
         row_ff <= cell_row;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/msq_back.sv =====
// ----------------------------------------------------------------------------
// msq_back: segment endpoint engine
// Divides out both edge fractions one bit a cycle, scales them by the cell
// step, adds the cell origin, saturates and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_back
   import msq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int INDEX_WIDTH  = DEF_INDEX_WIDTH,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic signed [FRAC_BITS+3:0]     origin_x,
   input  wire logic signed [FRAC_BITS+3:0]     origin_y,
   input  wire logic        [FRAC_BITS-1:0]     step_x,
   input  wire logic        [FRAC_BITS-1:0]     step_y,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire seg_ctrl_type                    in_ctrl,
   input  wire logic        [SAMPLE_WIDTH:0]    in_num0,
   input  wire logic        [SAMPLE_WIDTH:0]    in_den0,
   input  wire logic        [SAMPLE_WIDTH:0]    in_num1,
   input  wire logic        [SAMPLE_WIDTH:0]    in_den1,
   input  wire logic        [INDEX_WIDTH-1:0]   in_col,
   input  wire logic        [INDEX_WIDTH-1:0]   in_row,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic signed      [FRAC_BITS+3:0]     out_start_x,
   output logic signed      [FRAC_BITS+3:0]     out_start_y,
   output logic signed      [FRAC_BITS+3:0]     out_end_x,
   output logic signed      [FRAC_BITS+3:0]     out_end_y,
   output logic             [CASE_W-1:0]        out_case_idx,
   output logic                                 out_last
);

   localparam int CW     = FRAC_BITS + 4;
   localparam int MAG_W  = SAMPLE_WIDTH + 1;
   localparam int REM_W  = SAMPLE_WIDTH + 2;
   localparam int T_W    = FRAC_BITS + 1;
   localparam int IP_W   = INDEX_WIDTH + FRAC_BITS;
   localparam int FP_W   = T_W + FRAC_BITS;
   localparam int SUM_W  = IP_W + 3;
   localparam int CNT_W  = $clog2(FRAC_BITS);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_SUM, S_HOLD} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff;
   seg_ctrl_type       ctrl_ff;
   logic [INDEX_WIDTH-1:0] col_ff, row_ff;
   logic [MAG_W-1:0]   den_ff  [2];
   logic [REM_W-1:0]   rem_ff  [2];
   logic [FRAC_BITS-1:0] quo_ff [2];
   logic               full_ff [2];
   logic               zero_ff [2];
   logic [IP_W-1:0]    col_prod_ff, row_prod_ff;
   logic [FP_W-1:0]    frac_prod_ff [2];
   logic signed [CW-1:0] res_ff [4];

   logic [MAG_W-1:0]   num_sel [2];
   logic [MAG_W-1:0]   den_sel [2];
   logic [T_W-1:0]     t_val   [2];
   edge_type           edge_k  [2];
   logic signed [CW-1:0] coord [4];

   // Origin plus whole-cell offset plus in-cell offset, clamped to Q4.F.
   function automatic logic signed [CW-1:0] sat_coord(
      input logic signed [CW-1:0] org,
      input logic [IP_W-1:0]      prod,
      input logic [T_W-1:0]       off
   );
      logic signed [SUM_W-1:0] sum;
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi  = SUM_W'((1 << (CW - 1)) - 1);
      lo  = -SUM_W'(1 << (CW - 1));
      sum = SUM_W'(org) + $signed(SUM_W'(prod)) + $signed(SUM_W'(off));
      if (sum > hi) begin
         return CW'(hi);
      end else if (sum < lo) begin
         return CW'(lo);
      end
      return CW'(sum);
   endfunction

   assign in_ready  = (state_ff == S_IDLE);
   assign num_sel[0] = in_num0;
   assign num_sel[1] = in_num1;
   assign den_sel[0] = in_den0;
   assign den_sel[1] = in_den1;
   assign edge_k[0]  = ctrl_ff.edge0;
   assign edge_k[1]  = ctrl_ff.edge1;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (zero_ff[k]) begin
            t_val[k] = '0;
         end else if (full_ff[k]) begin
            t_val[k] = T_W'(1) << FRAC_BITS;
         end else begin
            t_val[k] = {1'b0, quo_ff[k]};
         end
      end
   end

   // Endpoint coordinates from the registered products.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         logic [T_W-1:0] frac;
         logic [T_W-1:0] xoff;
         logic [T_W-1:0] yoff;
         frac = frac_prod_ff[k][FP_W-1:FRAC_BITS];
         unique case (edge_k[k])
            EDGE_LEFT:   begin xoff = '0;              yoff = frac;           end
            EDGE_BOTTOM: begin xoff = frac;            yoff = '0;             end
            EDGE_TOP:    begin xoff = frac;            yoff = {1'b0, step_y}; end
            EDGE_RIGHT:  begin xoff = {1'b0, step_x};  yoff = frac;           end
         endcase
         coord[2*k]     = sat_coord(origin_x, col_prod_ff, xoff);
         coord[2*k + 1] = sat_coord(origin_y, row_prod_ff, yoff);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (in_valid) state_in = S_DIV;
         S_DIV:  if (cnt_ff == CNT_W'(FRAC_BITS - 1)) state_in = S_MUL;
         S_MUL:  state_in = S_SUM;
         S_SUM:  state_in = S_HOLD;
         S_HOLD: if (!out_valid || out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         out_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_HOLD && (!out_valid || out_ready)) begin
            out_valid <= 1'b1;
         end else if (out_ready) begin
            out_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            cnt_ff  <= '0;
            ctrl_ff <= in_ctrl;
            col_ff  <= in_col;
            row_ff  <= in_row;
            for (int k = 0; k < 2; k++) begin
               den_ff[k]  <= den_sel[k];
               rem_ff[k]  <= REM_W'(num_sel[k]);
               zero_ff[k] <= (den_sel[k] == '0);
               full_ff[k] <= (num_sel[k] >= den_sel[k]);
               quo_ff[k]  <= '0;
            end
         end
         S_DIV: begin
            cnt_ff <= cnt_ff + 1'b1;
            // Restoring division, one quotient bit per cycle.
            for (int k = 0; k < 2; k++) begin
               logic [REM_W-1:0] r2;
               r2 = {rem_ff[k][REM_W-2:0], 1'b0};
               if (r2 >= REM_W'(den_ff[k])) begin
                  rem_ff[k] <= r2 - REM_W'(den_ff[k]);
                  quo_ff[k] <= {quo_ff[k][FRAC_BITS-2:0], 1'b1};
               end else begin
                  rem_ff[k] <= r2;
                  quo_ff[k] <= {quo_ff[k][FRAC_BITS-2:0], 1'b0};
               end
            end
         end
         S_MUL: begin
            col_prod_ff <= IP_W'(col_ff) * IP_W'(step_x);
            row_prod_ff <= IP_W'(row_ff) * IP_W'(step_y);
            for (int k = 0; k < 2; k++) begin
               if (edge_k[k] == EDGE_BOTTOM || edge_k[k] == EDGE_TOP) begin
                  frac_prod_ff[k] <= FP_W'(t_val[k]) * FP_W'(step_x);
               end else begin
                  frac_prod_ff[k] <= FP_W'(t_val[k]) * FP_W'(step_y);
               end
            end
         end
         S_SUM: begin
            for (int i = 0; i < 4; i++) begin
               res_ff[i] <= coord[i];
            end
         end
         S_HOLD: begin
            if (!out_valid || out_ready) begin
               out_start_x  <= res_ff[0];
               out_start_y  <= res_ff[1];
               out_end_x    <= res_ff[2];
               out_end_y    <= res_ff[3];
               out_case_idx <= ctrl_ff.case_idx;
               out_last     <= ctrl_ff.last;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/marching_squares_cell_core.sv =====
// ----------------------------------------------------------------------------
// marching_squares_cell_core: isoline segments for one grid cell per request
// Each segment passes the front, the queue and the back's divide, multiply,
// sum and hold states before it appears on rsp. The back takes a new segment
// only once it is done with the last one; its restoring divider produces one
// fraction bit per cycle. Cells with every corner on the same side of the
// level leave the front without using the queue. Reset is synchronous
// and active high; it empties the pipeline and queue and loads the defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_core
   import msq_pkg::*;
#(
   parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
   parameter int INDEX_WIDTH  = DEF_INDEX_WIDTH,
   parameter int FRAC_BITS    = DEF_FRAC_BITS,
   localparam int CW          = FRAC_BITS + 4,
   localparam int CFG_W       = (SAMPLE_WIDTH > CW) ? SAMPLE_WIDTH : CW,
   localparam int REQ_W       = ((4 * SAMPLE_WIDTH + 2 * INDEX_WIDTH + 7) / 8) * 8,
   localparam int RSP_W       = ((4 * CW + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request: corner_a, corner_b, corner_c, corner_d, cell_col, cell_row.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_W-1:0]       req_tdata,
   // Response: start_x, start_y, end_x, end_y.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_W-1:0]       rsp_tdata,
   // Response user: case_index.
   output logic      [CASE_W-1:0]      rsp_tuser,
   output logic                        rsp_tlast,
   input  wire logic                   csr_we,
   input  wire logic [CFG_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int IW    = INDEX_WIDTH;
   localparam int MAG_W = SW + 1;
   localparam int CTRL_W  = $bits(seg_ctrl_type);
   localparam int ENTRY_W = CTRL_W + 4 * MAG_W + 2 * IW;

   // Register defaults: origin -1.0 and a step of about 2/49 of one.
   localparam logic signed [CW-1:0] ORIGIN_RESET = -(CW'(1) << FRAC_BITS);
   localparam logic [FRAC_BITS-1:0] STEP_RESET =
      FRAC_BITS'((4 * (2 ** FRAC_BITS) + 49) / 98);

   // Configuration registers.
   logic signed [SW-1:0]        level_ff;
   logic signed [CW-1:0]        origin_x_ff, origin_y_ff;
   logic        [FRAC_BITS-1:0] step_x_ff, step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= '0;
         origin_x_ff <= ORIGIN_RESET;
         origin_y_ff <= ORIGIN_RESET;
         step_x_ff   <= STEP_RESET;
         step_y_ff   <= STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_LEVEL:    level_ff    <= csr_wdata[SW-1:0];
            REG_ORIGIN_X: origin_x_ff <= csr_wdata[CW-1:0];
            REG_ORIGIN_Y: origin_y_ff <= csr_wdata[CW-1:0];
            REG_STEP_X:   step_x_ff   <= csr_wdata[FRAC_BITS-1:0];
            REG_STEP_Y:   step_y_ff   <= csr_wdata[FRAC_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Front: classification and per-segment expansion of each cell request.
   logic              f_valid, f_ready;
   seg_ctrl_type      f_ctrl;
   logic [MAG_W-1:0]  f_num0, f_den0, f_num1, f_den1;
   logic [IW-1:0]     f_col, f_row;

   msq_front #(
      .SAMPLE_WIDTH (SW),
      .INDEX_WIDTH  (IW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .level     (level_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .corner_a  (req_tdata[SW-1:0]),
      .corner_b  (req_tdata[2*SW-1:SW]),
      .corner_c  (req_tdata[3*SW-1:2*SW]),
      .corner_d  (req_tdata[4*SW-1:3*SW]),
      .cell_col  (req_tdata[4*SW+IW-1:4*SW]),
      .cell_row  (req_tdata[4*SW+2*IW-1:4*SW+IW]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_ctrl  (f_ctrl),
      .out_num0  (f_num0),
      .out_den0  (f_den0),
      .out_num1  (f_num1),
      .out_den1  (f_den1),
      .out_col   (f_col),
      .out_row   (f_row)
   );

   // The queue lets the front keep classifying while the back is dividing.
   logic               q_valid, q_ready;
   logic [ENTRY_W-1:0] q_in, q_out;
   seg_ctrl_type       q_ctrl;
   logic [MAG_W-1:0]   q_num0, q_den0, q_num1, q_den1;
   logic [IW-1:0]      q_col, q_row;

   assign q_in = {f_row, f_col, f_den1, f_num1, f_den0, f_num0, f_ctrl};
   assign {q_row, q_col, q_den1, q_num1, q_den0, q_num0, q_ctrl} = q_out;

   msq_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (q_in),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   // Back: fractions, scaling, saturation and the response register.
   logic signed [CW-1:0] b_start_x, b_start_y, b_end_x, b_end_y;

   msq_back #(
      .SAMPLE_WIDTH (SW),
      .INDEX_WIDTH  (IW),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .origin_x     (origin_x_ff),
      .origin_y     (origin_y_ff),
      .step_x       (step_x_ff),
      .step_y       (step_y_ff),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_ctrl      (q_ctrl),
      .in_num0      (q_num0),
      .in_den0      (q_den0),
      .in_num1      (q_num1),
      .in_den1      (q_den1),
      .in_col       (q_col),
      .in_row       (q_row),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_start_x  (b_start_x),
      .out_start_y  (b_start_y),
      .out_end_x    (b_end_x),
      .out_end_y    (b_end_y),
      .out_case_idx (rsp_tuser),
      .out_last     (rsp_tlast)
   );

   // Endpoints packed from the lowest bit up, zero fill to whole bytes.
   assign rsp_tdata = RSP_W'({b_end_y, b_end_x, b_start_y, b_start_x});

endmodule

`default_nettype wire

// ===== rtl/msq_checker.sv =====
// ----------------------------------------------------------------------------
// msq_checker: response port checks for the marching squares cell core
// Watches the response channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_checker
   import msq_pkg::*;
#(
   parameter int RSP_W = 80
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_W-1:0]  rsp_tdata,
   input wire logic [CASE_W-1:0] rsp_tuser,
   input wire logic              rsp_tlast
);

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response valid dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // Empty cells never produce a segment.
   a_no_empty_case: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 4'd0) && (rsp_tuser != 4'd15))
      else $error("segment emitted for an empty cell");

   // Only the two saddle cases have a segment that is not the last one.
   a_saddle_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tuser == 4'd5) || (rsp_tuser == 4'd10))
      else $error("non-final segment outside a saddle case");

endmodule

bind marching_squares_cell_core msq_checker #(
   .RSP_W (RSP_W)
) u_msq_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== test/msq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msq_scoreboard: segment predictor and scoreboard for the cell core
// Tracks register writes, predicts the segments of each accepted cell request
// and compares every accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module msq_scoreboard
   import msq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   input  wire logic             req_tready,
   input  wire logic [87:0]      req_tdata,
   input  wire logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire logic [79:0]      rsp_tdata,
   input  wire logic [CASE_W-1:0] rsp_tuser,
   input  wire logic             rsp_tlast,
   input  wire logic             csr_we,
   input  wire logic [CFG_INDEX_W-1:0] csr_index,
   input  wire logic [19:0]      csr_wdata,
   output int                    errors,
   output int                    pending
);

   typedef struct packed {
      logic [19:0]       sx;
      logic [19:0]       sy;
      logic [19:0]       ex;
      logic [19:0]       ey;
      logic [CASE_W-1:0] cidx;
      logic              last;
   } segment_t;

   segment_t segments_due[$];

   logic signed [15:0] level_q;
   logic signed [19:0] org_x_q, org_y_q;
   logic [15:0]        step_x_q, step_y_q;

   function automatic longint crossing(longint p, longint q);
      longint n, d, t;
      begin
         n = level_q - p;
         d = q - p;
         if (n < 0) n = -n;
         if (d < 0) d = -d;
         if (d == 0) return 0;
         t = (n << 16) / d;
         if (t > 65536) t = 65536;
         return t;
      end
   endfunction

   function automatic logic [19:0] place(longint org, longint idx, longint stp, longint t);
      longint v;
      begin
         v = org + idx * stp + ((t * stp) >>> 16);
         if (v < -524288) v = -524288;
         if (v > 524287) v = 524287;
         return v[19:0];
      end
   endfunction

   // Position of the crossing point on one edge of the cell.
   task automatic edge_point(input edge_type e, input longint s[4],
                             input longint col, input longint row,
                             output logic [19:0] x, output logic [19:0] y);
      longint tx, ty;
      begin
         case (e)
            EDGE_LEFT: begin
               tx = 0; ty = crossing(s[0], s[3]);
            end
            EDGE_BOTTOM: begin
               tx = crossing(s[0], s[1]); ty = 0;
            end
            EDGE_TOP: begin
               tx = crossing(s[3], s[2]); ty = 65536;
            end
            default: begin
               tx = 65536; ty = crossing(s[1], s[2]);
            end
         endcase
         x = place(longint'(org_x_q), col, longint'(step_x_q), tx);
         y = place(longint'(org_y_q), row, longint'(step_y_q), ty);
      end
   endtask

   task automatic predict_cell(input logic [87:0] d);
      longint s[4];
      longint col, row;
      logic [3:0] cs;
      edge_type e[4];
      int nseg;
      segment_t seg;
      begin
         cs = '0;
         for (int i = 0; i < 4; i++) begin
            s[i] = longint'($signed(d[16*i +: 16]));
            if (s[i] > level_q) cs[i] = 1'b1;
         end
         col = longint'(d[73:64]);
         row = longint'(d[83:74]);
         nseg = 1;
         case (cs)
            4'd1, 4'd14: begin e[0] = EDGE_LEFT;   e[1] = EDGE_BOTTOM; end
            4'd7, 4'd8:  begin e[0] = EDGE_LEFT;   e[1] = EDGE_TOP;    end
            4'd4, 4'd11: begin e[0] = EDGE_TOP;    e[1] = EDGE_RIGHT;  end
            4'd2, 4'd13: begin e[0] = EDGE_BOTTOM; e[1] = EDGE_RIGHT;  end
            4'd6, 4'd9:  begin e[0] = EDGE_BOTTOM; e[1] = EDGE_TOP;    end
            4'd3, 4'd12: begin e[0] = EDGE_LEFT;   e[1] = EDGE_RIGHT;  end
            4'd10: begin
               e[0] = EDGE_LEFT; e[1] = EDGE_BOTTOM;
               e[2] = EDGE_TOP;  e[3] = EDGE_RIGHT;
               nseg = 2;
            end
            4'd5: begin
               e[0] = EDGE_LEFT;   e[1] = EDGE_TOP;
               e[2] = EDGE_BOTTOM; e[3] = EDGE_RIGHT;
               nseg = 2;
            end
            default: nseg = 0;
         endcase
         for (int k = 0; k < nseg; k++) begin
            edge_point(e[2*k], s, col, row, seg.sx, seg.sy);
            edge_point(e[2*k+1], s, col, row, seg.ex, seg.ey);
            seg.cidx = cs;
            seg.last = (k == nseg - 1);
            segments_due.push_back(seg);
         end
      end
   endtask

   task automatic compare(input string name, input logic [19:0] want, input logic [19:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
         errors++;
      end
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      segment_t want;
      if (reset) begin
         level_q  <= 16'sd0;
         org_x_q  <= -20'sd65536;
         org_y_q  <= -20'sd65536;
         step_x_q <= 16'd2675;
         step_y_q <= 16'd2675;
      end else begin
         if (req_tvalid && req_tready) predict_cell(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (segments_due.size() == 0) begin
               $error("unexpected segment: no segment was due");
               errors++;
            end else begin
               want = segments_due.pop_front();
               compare("start_x", want.sx, rsp_tdata[19:0]);
               compare("start_y", want.sy, rsp_tdata[39:20]);
               compare("end_x", want.ex, rsp_tdata[59:40]);
               compare("end_y", want.ey, rsp_tdata[79:60]);
               compare("case_index", 20'(want.cidx), 20'(rsp_tuser));
               compare("last_segment", 20'(want.last), 20'(rsp_tlast));
            end
         end
         pending = segments_due.size();
         // Register writes take effect for requests accepted after this edge.
         if (csr_we) begin
            case (csr_index)
               REG_LEVEL:    level_q  <= csr_wdata[15:0];
               REG_ORIGIN_X: org_x_q  <= csr_wdata;
               REG_ORIGIN_Y: org_y_q  <= csr_wdata;
               REG_STEP_X:   step_x_q <= csr_wdata[15:0];
               REG_STEP_Y:   step_y_q <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the marching squares cell core
// Drives directed and random cell requests through several register settings
// and stall patterns; the scoreboard beside the core predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   import msq_pkg::*;

   // Margin after every due segment has arrived, so that anything still in
   // flight is covered.
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Request fields from bit 0 up: corner_a, corner_b, corner_c, corner_d,
   // cell_col, cell_row, zero fill.
   logic [87:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   // Response fields from bit 0 up: start_x, start_y, end_x, end_y.
   logic [79:0]            rsp_tdata;
   // Response user field: case_index.
   logic [CASE_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CFG_INDEX_W-1:0] csr_index = REG_LEVEL;
   logic [19:0]            csr_wdata = '0;

   int errors;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles = 0;
   logic signed [15:0] cur_level = 16'sd0;

   always #4 clock = ~clock;

   marching_squares_cell_core DUT (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata
   );

   msq_scoreboard u_scoreboard (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_index, .csr_wdata,
      .errors, .pending
   );

   // The receiver throttles independently of the sender.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: a hung core ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Sends one cell request. Called at a falling edge; returns at the falling
   // edge after the request was taken. The valid line is lowered only when
   // an idle gap is inserted, so it never toggles twice in one step.
   task automatic send_cell(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic signed [15:0] c, input logic signed [15:0] d,
                            input logic [9:0] col, input logic [9:0] row);
      begin
         if ($urandom_range(99) < send_idle_pct) begin
            req_tvalid = 1'b0;
            do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
         end
         req_tdata  = {4'b0, row, col, d, c, b, a};
         req_tvalid = 1'b1;
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
      end
   endtask

   // Lets every outstanding segment arrive, then some extra cycles.
   task automatic drain();
      begin
         req_tvalid = 1'b0;
         while (pending != 0) @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [19:0] val);
      begin
         csr_we    = 1'b1;
         csr_index = idx;
         csr_wdata = val;
         if (idx == REG_LEVEL) cur_level = val[15:0];
         @(negedge clock);
      end
   endtask

   task automatic load_setting(input logic [15:0] lvl, input logic [19:0] ox,
                               input logic [19:0] oy, input logic [15:0] sx,
                               input logic [15:0] sy);
      begin
         write_reg(REG_LEVEL, {4'b0, lvl});
         write_reg(REG_ORIGIN_X, ox);
         write_reg(REG_ORIGIN_Y, oy);
         write_reg(REG_STEP_X, {4'b0, sx});
         write_reg(REG_STEP_Y, {4'b0, sy});
         csr_we = 1'b0;
      end
   endtask

   // A corner on the chosen side of the threshold; a corner below it is sometimes
   // exactly on it, so that a crossing lands on a corner of its edge.
   function automatic logic signed [15:0] corner_near(input bit above);
      int v;
      begin
         case ($urandom_range(3))
            0: v = $urandom_range(15);
            1: v = $urandom_range(2000);
            default: v = $urandom_range(65535);
         endcase
         if (!above && v > 0 && $urandom_range(9) == 0) v = 0;
         v = above ? cur_level + 1 + v : cur_level - v;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return 16'(v);
      end
   endfunction

   task automatic random_cell();
      logic signed [15:0] s[4];
      logic [3:0] cs;
      logic [9:0] col, row;
      begin
         cs = 4'($urandom_range(15));
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(9) == 0) s[i] = 16'($urandom);
            else s[i] = corner_near(cs[i]);
         end
         // Mostly small indexes, with the full range now and then.
         col = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(63));
         row = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(63));
         send_cell(s[0], s[1], s[2], s[3], col, row);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset settings: every case index, full-scale
      // samples, the corner indexes and a crossing at exactly 1.0.
      for (int k = 0; k < 16; k++) begin
         send_cell(k[0] ? 16'sd32767 : -16'sd32768, k[1] ? 16'sd100 : -16'sd300,
                   k[2] ? 16'sd7 : -16'sd1, k[3] ? 16'sd32767 : -16'sd32768,
                   10'(k * 60), 10'(1023 - k * 60));
      end
      send_cell(16'sd10, 16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd0);
      send_cell(-16'sd10, 16'sd0, 16'sd20, 16'sd40, 10'd1023, 10'd1023);
      send_cell(16'sd1, -16'sd1, 16'sd1, -16'sd1, 10'd49, 10'd0);
      send_cell(-16'sd1, 16'sd1, -16'sd1, 16'sd1, 10'd0, 10'd49);
      drain();

      // Extreme settings: largest steps push coordinates into saturation at the
      // top end, zero steps pin that coordinate to its origin.
      load_setting(16'h7FFF, 20'h7FFFF, 20'h80000, 16'hFFFF, 16'h0000);
      for (int k = 0; k < 4; k++)
         send_cell(16'sd32767, -16'sd32768, 16'sd32767, 16'sd0, 10'd1023, 10'd1023);
      drain();
      load_setting(16'h8000, 20'h80000, 20'h7FFFF, 16'h0000, 16'hFFFF);
      send_cell(-16'sd32768, -16'sd32767, 16'sd32767, -16'sd32768, 10'd1023, 10'd0);
      send_cell(-16'sd32767, -16'sd32768, -16'sd32768, -16'sd32767, 10'd0, 10'd1023);
      drain();

      // Random part: eight phases of 137 requests, each but the first under a fresh
      // register setting. Stall patterns move from sender-light to
      // receiver-light to none.
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 3) begin
            send_idle_pct = 12; recv_idle_pct = 61;
         end else if (ph < 6) begin
            send_idle_pct = 61; recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (ph == 1)
            load_setting(16'hFFFF, 20'hFFFFF, 20'h00001, 16'hFFFF, 16'hFFFF);
         else if (ph > 0)
            load_setting(16'($urandom), 20'($urandom), 20'($urandom),
                         $urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(4096)),
                         $urandom_range(2) == 0 ? 16'($urandom) : 16'($urandom_range(4096)));
         for (int n = 0; n < 137; n++) begin
            random_cell();
            // Once in mid-phase the sender holds off until all is delivered.
            if (ph == 2 && n == 60) begin
               req_tvalid = 1'b0;
               while (pending != 0) @(negedge clock);
            end
         end
         drain();
      end

      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
